[rtl/core/prvs_pkg.sv]
// ----------------------------------------------------------------------------
// prvs_pkg
// Shared types and constants of the page replacement victim selector.
// ----------------------------------------------------------------------------
package prvs_pkg;

  localparam int SLOTS        = 16;
  localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_FIELD_W = 4;
  localparam int VIC_W        = 4;
  localparam int AGE_W        = 32;
  localparam int STAMP_W      = 32;
  localparam int ONES_W       = $clog2(AGE_W + 1);
  localparam int CMD_W        = 3;
  localparam int POLICY_W     = 2;
  localparam int IN_TDATA_W   = ((SLOT_FIELD_W + AGE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((VIC_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSTALL = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_AGE     = 3'd2,
    CMD_MARK    = 3'd3,
    CMD_SELECT  = 3'd4
  } cmd_t;

  typedef enum logic [POLICY_W-1:0] {
    POL_AGE  = 2'd0,
    POL_ONES = 2'd1,
    POL_FIFO = 2'd2
  } policy_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic apply;
    logic scan_start;
    logic restamp;
    logic load_out;
  } ctrl_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic scan_done;
    logic any;
    logic best_accessed;
  } status_t;

endpackage

[rtl/core/prvs_datapath.sv]
// ----------------------------------------------------------------------------
// prvs_datapath
// Slot tables, stamp counter and the one-slot-per-cycle least-key scan.
// ----------------------------------------------------------------------------
module prvs_datapath
  import prvs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctrl_t                   ctrl,
  input  policy_t                 mode,
  input  cmd_t                    cmd,
  input  logic [SLOT_FIELD_W-1:0] slot,
  input  logic [AGE_W-1:0]        age_value,
  output status_t                 status,
  output logic [SLOT_W-1:0]       best_idx
);

  function automatic logic [ONES_W-1:0] count_ones(input logic [AGE_W-1:0] v);
    logic [ONES_W-1:0] nib [AGE_W/4];
    logic [ONES_W-1:0] sum;
    sum = '0;
    for (int i = 0; i < AGE_W / 4; i++) begin
      nib[i] = ONES_W'(v[4*i]) + ONES_W'(v[4*i+1]) + ONES_W'(v[4*i+2]) + ONES_W'(v[4*i+3]);
    end
    for (int i = 0; i < AGE_W / 4; i++) begin
      sum = sum + nib[i];
    end
    return sum;
  endfunction

  logic [AGE_W-1:0]   age_r   [SLOTS];
  logic [STAMP_W-1:0] stamp_r [SLOTS];
  logic [SLOTS-1:0]   present_r;
  logic [SLOTS-1:0]   accessed_r;
  logic [STAMP_W-1:0] stamp_cnt_r;

  logic              slot_ok;
  logic [SLOT_W-1:0] wr_idx;

  assign slot_ok = (32'(slot) < SLOTS);
  assign wr_idx  = SLOT_W'(slot);

  // Tables: written at one address per cycle, read by the scan in a clocked block.
  always_ff @(posedge clk) begin
    if (ctrl.apply && slot_ok) begin
      case (cmd)
        CMD_INSTALL: begin
          age_r[wr_idx]   <= (mode == POL_ONES) ? {AGE_W{1'b1}} : '0;
          stamp_r[wr_idx] <= stamp_cnt_r;
        end
        CMD_AGE: age_r[wr_idx] <= age_value;
        default: ;
      endcase
    end
    if (ctrl.restamp) begin
      stamp_r[best_idx] <= stamp_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r   <= '0;
      accessed_r  <= '0;
      stamp_cnt_r <= '0;
    end else begin
      if (ctrl.apply && slot_ok) begin
        case (cmd)
          CMD_INSTALL: begin
            present_r[wr_idx]  <= 1'b1;
            accessed_r[wr_idx] <= 1'b0;
            stamp_cnt_r        <= stamp_cnt_r + 1'b1;
          end
          CMD_REMOVE: begin
            present_r[wr_idx]  <= 1'b0;
            accessed_r[wr_idx] <= 1'b0;
          end
          CMD_MARK: accessed_r[wr_idx] <= 1'b1;
          default: ;
        endcase
      end
      if (ctrl.restamp) begin
        accessed_r[best_idx] <= 1'b0;
        stamp_cnt_r          <= stamp_cnt_r + 1'b1;
      end
    end
  end

  // Scan: the first stage reads one slot, the second compares it with the best so far.
  logic               scan_active_r;
  logic [SLOT_W-1:0]  scan_idx_r;
  logic               rd_valid_r;
  logic               rd_last_r;
  logic [SLOT_W-1:0]  rd_idx_r;
  logic               rd_present_r;
  logic [AGE_W-1:0]   rd_age_r;
  logic [STAMP_W-1:0] rd_stamp_r;
  logic               done_r;
  logic               any_r;
  logic [SLOT_W-1:0]  best_idx_r;
  logic [ONES_W-1:0]  best_ones_r;
  logic [AGE_W-1:0]   best_key_r;

  logic              scan_last;
  logic [ONES_W-1:0] cand_ones;
  logic [AGE_W-1:0]  cand_key;
  logic              better;

  assign scan_last = (scan_idx_r == SLOT_W'(SLOTS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_active_r <= 1'b0;
      scan_idx_r    <= '0;
      rd_valid_r    <= 1'b0;
      rd_last_r     <= 1'b0;
    end else begin
      rd_valid_r <= scan_active_r;
      rd_last_r  <= scan_active_r && scan_last;
      if (ctrl.scan_start) begin
        scan_active_r <= 1'b1;
        scan_idx_r    <= '0;
      end else if (scan_active_r) begin
        if (scan_last) begin
          scan_active_r <= 1'b0;
        end else begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= scan_idx_r;
    rd_present_r <= present_r[scan_idx_r];
    rd_age_r     <= age_r[scan_idx_r];
    rd_stamp_r   <= stamp_r[scan_idx_r];
  end

  always_comb begin
    cand_ones = (mode == POL_ONES) ? count_ones(rd_age_r) : '0;
    cand_key  = (mode == POL_FIFO) ? rd_stamp_r : rd_age_r;
    if (!any_r) begin
      better = 1'b1;
    end else if (mode == POL_ONES) begin
      better = (cand_ones < best_ones_r) ||
               ((cand_ones == best_ones_r) && (cand_key < best_key_r));
    end else begin
      better = (cand_key < best_key_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r     <= 1'b0;
      any_r      <= 1'b0;
      best_idx_r <= '0;
    end else begin
      done_r <= rd_valid_r && rd_last_r;
      if (ctrl.scan_start) begin
        any_r <= 1'b0;
      end else if (rd_valid_r && rd_present_r && better) begin
        any_r      <= 1'b1;
        best_idx_r <= rd_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid_r && rd_present_r && better && !ctrl.scan_start) begin
      best_ones_r <= cand_ones;
      best_key_r  <= cand_key;
    end
  end

  assign best_idx             = best_idx_r;
  assign status.scan_done     = done_r;
  assign status.any           = any_r;
  assign status.best_accessed = accessed_r[best_idx_r];

endmodule

[rtl/core/prvs_ctrl.sv]
// ----------------------------------------------------------------------------
// prvs_ctrl
// Sequencer: takes words, starts scans, decides on second chances, hands off results.
// ----------------------------------------------------------------------------
module prvs_ctrl
  import prvs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  cmd_t    cmd,
  input  policy_t mode,
  input  status_t status,
  input  logic    out_busy,
  output logic    in_ready,
  output ctrl_t   ctrl
);

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt       = state_r;
    ctrl.apply      = 1'b0;
    ctrl.scan_start = 1'b0;
    ctrl.restamp    = 1'b0;
    ctrl.load_out   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (cmd == CMD_SELECT) begin
            ctrl.scan_start = 1'b1;
            state_nxt       = ST_SCAN;
          end else begin
            ctrl.apply = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          // An accessed oldest slot gets its second chance and the search runs again.
          if (status.any && (mode == POL_FIFO) && status.best_accessed) begin
            ctrl.restamp    = 1'b1;
            ctrl.scan_start = 1'b1;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (!out_busy) begin
          ctrl.load_out = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[rtl/core/page_replacement_victim_select_top.sv]
// Select scans all SLOTS slots per pass and then loads the result register; the
// second-chance policy may run up to SLOTS + 1 passes, one slot read per cycle.
// One word at a time: no new word is taken until a select has loaded its result register.
// Reset (synchronous, rst_n low): clears present and accessed flags, the stamp
// counter, the policy and all handshake state; the age and stamp tables are not cleared.
// ----------------------------------------------------------------------------
// page_replacement_victim_select_top
// Page slot table with least-age, fewest-ones and second-chance FIFO victim selection.
// ----------------------------------------------------------------------------
module page_replacement_victim_select_top
  import prvs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [POLICY_W-1:0]    cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // slot [3:0], age_value [35:4], zero fill
  input  logic [CMD_W-1:0]       in_tuser,   // cmd [2:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // victim_slot [3:0], zero fill
  output logic                   out_tuser   // victim_found [0]
);

  logic [POLICY_W-1:0] policy_r;
  policy_t             mode;
  cmd_t                cmd;
  ctrl_t               ctrl;
  status_t             status;
  logic [SLOT_W-1:0]   best_idx;
  logic                out_valid_r;
  logic [VIC_W-1:0]    out_slot_r;
  logic                out_found_r;
  logic                out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_AGE;
    end else if (cfg_we) begin
      policy_r <= cfg_wdata;
    end
  end

  // The unused policy code falls back to least age.
  always_comb begin
    if (policy_r == POL_ONES) begin
      mode = POL_ONES;
    end else if (policy_r == POL_FIFO) begin
      mode = POL_FIFO;
    end else begin
      mode = POL_AGE;
    end
  end

  assign cmd      = cmd_t'(in_tuser);
  assign out_busy = out_valid_r && !out_tready;

  prvs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .cmd      (cmd),
    .mode     (mode),
    .status   (status),
    .out_busy (out_busy),
    .in_ready (in_tready),
    .ctrl     (ctrl)
  );

  prvs_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .mode      (mode),
    .cmd       (cmd),
    .slot      (in_tdata[SLOT_FIELD_W-1:0]),
    .age_value (in_tdata[SLOT_FIELD_W +: AGE_W]),
    .status    (status),
    .best_idx  (best_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      out_slot_r  <= status.any ? VIC_W'(best_idx) : '0;
      out_found_r <= status.any;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_slot_r);
  assign out_tuser  = out_found_r;

`ifndef NO_ASSERTIONS
  a_no_victim_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("result without a victim carries a nonzero slot");

  a_fifo_victim_unaccessed: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.load_out && status.any && (mode == POL_FIFO)) |-> !status.best_accessed)
    else $error("second-chance victim still has its accessed bit set");

  a_select_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == CMD_SELECT)) |=> !in_tready)
    else $error("new word accepted while a select is in progress");
`endif

endmodule

[bench/victim_checker.sv]
// ----------------------------------------------------------------------------
// victim_checker
// Watches the command and result streams of the victim selector, keeps its
// own copy of the slot table and policy, predicts each victim and compares.
// ----------------------------------------------------------------------------
module victim_checker
  import prvs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [POLICY_W-1:0]    cfg_wdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // slot [3:0], age_value [35:4], zero fill
  input  logic [CMD_W-1:0]       in_tuser,   // cmd [2:0]
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // victim_slot [3:0], zero fill
  input  logic                   out_tuser,  // victim_found [0]
  output int                     fail_count,
  output int                     pending_count,
  output int                     victims_checked
);

  typedef struct packed {
    logic [VIC_W-1:0] slot;
    logic             found;
  } victim_t;

  logic                slot_present  [SLOTS];
  logic                slot_accessed [SLOTS];
  logic [AGE_W-1:0]    slot_age      [SLOTS];
  logic [STAMP_W-1:0]  slot_stamp    [SLOTS];
  logic [STAMP_W-1:0]  stamp_next;
  logic [POLICY_W-1:0] cur_policy;
  victim_t             predicted_victims [$];

  initial begin
    fail_count      = 0;
    pending_count   = 0;
    victims_checked = 0;
  end

  function automatic int unsigned ones_in(input logic [AGE_W-1:0] v);
    int unsigned n;
    n = 0;
    for (int b = 0; b < AGE_W; b++) n += v[b];
    return n;
  endfunction

  // Smallest key among present slots (fewest ones first under the ones policy); ties keep the lowest index.
  function automatic logic find_least(input policy_t mode, output int unsigned who);
    logic              any;
    logic              better;
    logic [AGE_W-1:0]  key;
    logic [AGE_W-1:0]  best_key;
    int unsigned       ones;
    int unsigned       best_ones;
    any       = 1'b0;
    who       = 0;
    best_key  = '0;
    best_ones = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_present[i]) begin
        key  = (mode == POL_FIFO) ? slot_stamp[i] : slot_age[i];
        ones = (mode == POL_ONES) ? ones_in(key) : 0;
        if (!any) begin
          better = 1'b1;
        end else if (mode == POL_ONES) begin
          better = (ones < best_ones) || (ones == best_ones && key < best_key);
        end else begin
          better = key < best_key;
        end
        if (better) begin
          any       = 1'b1;
          who       = i;
          best_key  = key;
          best_ones = ones;
        end
      end
    end
    return any;
  endfunction

  task automatic apply_command(input logic [CMD_W-1:0]        cmd,
                               input logic [SLOT_FIELD_W-1:0] slot,
                               input logic [AGE_W-1:0]        age);
    policy_t     mode;
    int unsigned who;
    int unsigned pass;
    logic        found;
    victim_t     v;
    case (cur_policy)
      POL_ONES: mode = POL_ONES;
      POL_FIFO: mode = POL_FIFO;
      default:  mode = POL_AGE;
    endcase
    if (cmd == CMD_SELECT) begin
      found = find_least(mode, who);
      if (found && mode == POL_FIFO) begin
        // Second chance: an accessed oldest slot is cleared, restamped and skipped.
        pass = 0;
        while (pass <= SLOTS && slot_accessed[who]) begin
          slot_accessed[who] = 1'b0;
          slot_stamp[who]    = stamp_next;
          stamp_next         = stamp_next + 1'b1;
          void'(find_least(mode, who));
          pass++;
        end
      end
      v.slot  = found ? who[VIC_W-1:0] : '0;
      v.found = found;
      predicted_victims.push_back(v);
    end else if (slot < SLOTS) begin
      case (cmd)
        CMD_INSTALL: begin
          slot_present[slot]  = 1'b1;
          slot_accessed[slot] = 1'b0;
          slot_age[slot]      = (mode == POL_ONES) ? '1 : '0;
          slot_stamp[slot]    = stamp_next;
          stamp_next          = stamp_next + 1'b1;
        end
        CMD_REMOVE: begin
          slot_present[slot]  = 1'b0;
          slot_accessed[slot] = 1'b0;
        end
        CMD_AGE:  slot_age[slot] = age;
        CMD_MARK: slot_accessed[slot] = 1'b1;
        default: ;
      endcase
    end
  endtask

  always @(posedge clk) begin
    victim_t exp_v;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_present[i]  = 1'b0;
        slot_accessed[i] = 1'b0;
        slot_age[i]      = '0;
        slot_stamp[i]    = '0;
      end
      stamp_next = '0;
      cur_policy = POL_AGE;
      predicted_victims.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (predicted_victims.size() == 0) begin
          $display("%0t: victim word with nothing expected: slot %0d found %0b",
                   $time, out_tdata[VIC_W-1:0], out_tuser);
          fail_count++;
        end else begin
          exp_v = predicted_victims.pop_front();
          victims_checked++;
          if (out_tdata[VIC_W-1:0] !== exp_v.slot || out_tuser !== exp_v.found) begin
            $display("%0t: victim mismatch: expected slot %0d found %0b, got slot %0d found %0b",
                     $time, exp_v.slot, exp_v.found, out_tdata[VIC_W-1:0], out_tuser);
            fail_count++;
          end
        end
      end
      if (cfg_we) cur_policy = cfg_wdata;
      if (in_tvalid && in_tready)
        apply_command(in_tuser, in_tdata[SLOT_FIELD_W-1:0], in_tdata[SLOT_FIELD_W +: AGE_W]);
    end
    pending_count = predicted_victims.size();
  end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives commands and policy writes into the victim selector under several
// idling patterns; the checker beside the block predicts and compares victims.
// ----------------------------------------------------------------------------
module tb_top;
  import prvs_pkg::*;

  localparam int              RESET_CYCLES  = 10;
  localparam int              PHASES        = 8;
  localparam int              PHASE_WORDS   = 125;
  localparam int              SETTLE_CYCLES = 8;
  localparam int              TAIL_CYCLES   = SLOTS + 8;
  localparam int              CYCLE_LIMIT   = 2_000_000;
  localparam logic [CMD_W-1:0]    CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0]    CMD_SPARE_HI = 3'd7;
  localparam logic [POLICY_W-1:0] POL_SPARE    = 2'd3;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [POLICY_W-1:0]    cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // slot [3:0], age_value [35:4], zero fill
  logic [CMD_W-1:0]       in_tuser   = '0;  // cmd [2:0]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // victim_slot [3:0], zero fill
  logic                   out_tuser;        // victim_found [0]

  int fail_count;
  int pending_count;
  int victims_checked;
  int gap_pct   = 0;
  int stall_pct = 0;
  int cycles    = 0;
  int words_sent = 0;
  int directed_words = 0;

  page_replacement_victim_select_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  victim_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .victims_checked (victims_checked)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // One command word; the sender may idle first, then holds the word until taken.
  task automatic send_word(input logic [CMD_W-1:0]        cmd,
                           input logic [SLOT_FIELD_W-1:0] slot,
                           input logic [AGE_W-1:0]        age);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_TDATA_W - SLOT_FIELD_W - AGE_W){1'b0}}, age, slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_policy(input logic [POLICY_W-1:0] p);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [AGE_W-1:0] random_age();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return '0;
      2:       return '1;
      3:       return $urandom & $urandom & $urandom;
      4:       return 32'h1 << $urandom_range(0, AGE_W - 1);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  task automatic random_word();
    int unsigned      roll;
    logic [CMD_W-1:0] cmd;
    roll = $urandom_range(0, 99);
    if (roll < 20)      cmd = CMD_INSTALL;
    else if (roll < 30) cmd = CMD_REMOVE;
    else if (roll < 50) cmd = CMD_AGE;
    else if (roll < 70) cmd = CMD_MARK;
    else if (roll < 95) cmd = CMD_SELECT;
    else                cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    send_word(cmd, SLOT_FIELD_W'($urandom_range(0, (1 << SLOT_FIELD_W) - 1)), random_age());
  endtask

  initial begin
    logic [POLICY_W-1:0] phase_policy [PHASES];
    phase_policy = '{POL_AGE, POL_ONES, POL_FIFO, POL_SPARE,
                     POL_FIFO, POL_ONES, POL_AGE, POL_FIFO};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty table, ties, reinstall, writes to absent slots,
    // spare commands, and each policy including the spare code.
    write_policy(POL_AGE);
    send_word(CMD_SELECT,  4'd0,  '0);
    send_word(CMD_INSTALL, 4'd0,  '0);
    send_word(CMD_INSTALL, 4'd15, '1);
    send_word(CMD_AGE,     4'd0,  '1);
    send_word(CMD_AGE,     4'd15, '0);
    send_word(CMD_SELECT,  4'd9,  '1);
    send_word(CMD_SPARE_LO, 4'd15, '1);
    send_word(CMD_SPARE_HI, 4'd0,  '1);
    send_word(CMD_MARK,    4'd3,  '0);
    send_word(CMD_AGE,     4'd3,  32'hDEAD_BEEF);
    send_word(CMD_INSTALL, 4'd3,  '0);
    send_word(CMD_SELECT,  4'd0,  '0);
    send_word(CMD_INSTALL, 4'd15, '0);
    send_word(CMD_REMOVE,  4'd3,  '0);
    send_word(CMD_SELECT,  4'd0,  '0);
    write_policy(POL_ONES);
    send_word(CMD_INSTALL, 4'd5,  '0);
    send_word(CMD_INSTALL, 4'd6,  '0);
    send_word(CMD_AGE,     4'd6,  32'h8000_0000);
    send_word(CMD_AGE,     4'd5,  32'h0000_0001);
    send_word(CMD_SELECT,  4'd0,  '0);
    write_policy(POL_FIFO);
    send_word(CMD_MARK,    4'd0,  '0);
    send_word(CMD_MARK,    4'd15, '0);
    send_word(CMD_SELECT,  4'd0,  '0);
    write_policy(POL_SPARE);
    send_word(CMD_SELECT,  4'd0,  '0);
    directed_words = words_sent;

    for (int ph = 0; ph < PHASES; ph++) begin
      write_policy(phase_policy[ph]);
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 85; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 85; end
        default: begin gap_pct = 25; stall_pct = 25; end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 99) == 0) begin
          // Empty the table so selects also see it bare.
          for (int s = 0; s < SLOTS; s++)
            send_word(CMD_REMOVE, SLOT_FIELD_W'(s), random_age());
          send_word(CMD_SELECT, SLOT_FIELD_W'($urandom_range(0, SLOTS - 1)), random_age());
        end else if ($urandom_range(0, 99) == 0) begin
          wait_drained();
        end
        random_word();
      end
    end

    gap_pct   = 0;
    stall_pct = 0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d command words (%0d directed) across all policy codes and idling patterns.",
             words_sent, directed_words);
    $display("Compared %0d victim words, %0d mismatches.", victims_checked, fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[page_replacement_victim_select_top.f]
rtl/core/prvs_pkg.sv
rtl/core/prvs_datapath.sv
rtl/core/prvs_ctrl.sv
rtl/core/page_replacement_victim_select_top.sv
bench/victim_checker.sv
bench/tb_top.sv
